@@ rtl/dchs_pkg.sv @@
// Package for the display CAN handshake sequencer: payload structs,
// phase codes, frame identifiers and the request struct between front and back.
// No dependencies.
package dchs_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  rx_byte0;
    logic [7:0]  rx_byte1;
    logic [7:0]  rx_byte2;
  } in_item_t;

  typedef struct packed {
    logic        has_frame;
    logic [10:0] tx_id;
    logic [7:0]  tx_byte0;
    logic [7:0]  tx_byte1;
    logic [7:0]  tx_byte2;
    logic [7:0]  tx_byte3;
    logic [7:0]  tx_byte4;
    logic [7:0]  tx_byte5;
    logic [7:0]  tx_byte6;
    logic [7:0]  tx_byte7;
    logic        last_of_item;
    logic [3:0]  phase_code;
  } out_item_t;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    logic       tick;
    logic       restart;
    logic       ack_1c1;    // 1C1 frame, answer with 5C1
    logic       panel;      // 1C1 frame carrying 70
    logic       request;    // 3CF 61 11
    logic       ack;        // bit 10 id with byte 74
    logic [9:0] ack_id;
  } req_t;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_FRAME   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [3:0] PH_SILENT    = 4'd0;
  localparam logic [3:0] PH_SAWREQ    = 4'd1;
  localparam logic [3:0] PH_HELLO     = 4'd2;
  localparam logic [3:0] PH_WAITPANEL = 4'd3;
  localparam logic [3:0] PH_REGTEXT   = 4'd4;
  localparam logic [3:0] PH_REGNAV    = 4'd5;
  localparam logic [3:0] PH_SETTLE    = 4'd6;
  localparam logic [3:0] PH_POWERON   = 4'd7;
  localparam logic [3:0] PH_WARMUP    = 4'd8;
  localparam logic [3:0] PH_SETCLOCK  = 4'd9;
  localparam logic [3:0] PH_DONE      = 4'd10;

  localparam logic [10:0] ID_ANNOUNCE = 11'h3AF;
  localparam logic [10:0] ID_REQUEST  = 11'h3CF;
  localparam logic [10:0] ID_TEXT     = 11'h151;
  localparam logic [10:0] ID_NAV      = 11'h1F1;
  localparam logic [10:0] ID_PANEL    = 11'h1C1;
  localparam logic [10:0] ID_PANELACK = 11'h5C1;
  localparam logic [10:0] ID_ACK_BIT  = 11'h400;

  localparam logic [7:0] B_BEAT     = 8'hB9;
  localparam logic [7:0] B_ANNOUNCE = 8'hBA;
  localparam logic [7:0] B_ON       = 8'h70;
  localparam logic [7:0] B_ACK      = 8'h74;
  localparam logic [7:0] B_REQ0     = 8'h61;
  localparam logic [7:0] B_REQ1     = 8'h11;

  localparam logic [31:0] WARMUP_MS     = 32'd50;
  localparam logic [1:0]  HELLO_REPEATS = 2'd3;

  localparam logic [2:0] CFG_ANN_EN  = 3'd0;
  localparam logic [2:0] CFG_CLOCK   = 3'd1;
  localparam logic [2:0] CFG_HELLO   = 3'd2;
  localparam logic [2:0] CFG_BEAT    = 3'd3;
  localparam logic [2:0] CFG_ANN     = 3'd4;
  localparam logic [2:0] CFG_ACK     = 3'd5;
  localparam logic [2:0] CFG_SETTLE  = 3'd6;
  localparam logic [2:0] CFG_RETRY   = 3'd7;

  function automatic out_item_t frame1(input logic [10:0] id, input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.has_frame = 1'b1;
    r.tx_id = id;
    r.tx_byte0 = b;
    return r;
  endfunction

endpackage

@@ rtl/dchs_front.sv @@
// Front part: accepts input items, classifies them into a request and
// holds them in a two-entry queue. Depends on dchs_pkg.
module dchs_front import dchs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_take,
  output req_t     q_req
);

  req_t       slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  req_t       cls;
  logic       is_frame, len1, len3;
  logic       push, pop;

  always_comb begin
    is_frame = in_data.kind == KIND_FRAME;
    len1 = in_data.frame_len != 4'd0;
    len3 = in_data.frame_len >= 4'd3;
    cls = '0;
    cls.tick = in_data.kind == KIND_TICK;
    cls.restart = in_data.kind == KIND_RESTART;
    cls.ack_1c1 = is_frame && in_data.frame_id == ID_PANEL;
    cls.panel = cls.ack_1c1 && len1 && in_data.rx_byte0 == B_ON;
    cls.request = is_frame && in_data.frame_id == ID_REQUEST && len3 &&
                  in_data.rx_byte0 == B_REQ0 && in_data.rx_byte1 == B_REQ1;
    cls.ack = is_frame && (in_data.frame_id & ID_ACK_BIT) != 11'd0 && len1 &&
              in_data.rx_byte0 == B_ACK;
    cls.ack_id = in_data.frame_id[9:0];
  end

  assign in_ready = count != 2'd2;
  assign q_valid  = count != 2'd0;
  assign q_req    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/dchs_back.sv @@
// Back part: holds the session state and configuration, executes one
// request per pass and delivers its results through an output register.
// Depends on dchs_pkg.
module dchs_back import dchs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_take,
  input  req_t        q_req,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic        announce_enable;
  logic [31:0] clock_text;
  logic [15:0] hello_delay_ms, heartbeat_ms, announce_ms, ack_timeout_ms;
  logic [15:0] settle_ms, retry_ms;

  logic [31:0] time_ms, deadline, next_beat, next_announce;
  logic [3:0]  phase;
  logic [1:0]  hello_count;
  logic        panel_seen, registered, announced;

  // Second result of the item, waiting behind the first.
  logic        pend_valid;
  out_item_t   pend;

  logic [31:0] time_next, deadline_next, next_beat_next, next_announce_next;
  logic [3:0]  phase_next;
  logic [1:0]  hello_count_next;
  logic        panel_seen_next, registered_next, announced_next;
  out_item_t   r0, r1;
  logic        n_res;
  logic [31:0] now;
  logic [1:0]  hc;
  logic        beat;
  out_item_t   f;

  function automatic logic reached(input logic [31:0] t, input logic [31:0] at);
    logic [31:0] d;
    d = t - at;
    return ~d[31];
  endfunction

  // Out register is free when empty or being taken with no pending result.
  logic slot_free;
  assign slot_free = (!out_valid || out_ready) && !pend_valid;
  assign q_take = q_valid && slot_free;

  always_comb begin
    time_next = time_ms;
    deadline_next = deadline;
    next_beat_next = next_beat;
    next_announce_next = next_announce;
    phase_next = phase;
    hello_count_next = hello_count;
    panel_seen_next = panel_seen;
    registered_next = registered;
    announced_next = announced;
    f = '0;
    beat = 1'b0;
    hc = 2'd0;
    now = time_ms + 32'd1;
    if (q_req.tick) begin
      time_next = now;
      if (registered && reached(now, next_beat)) begin
        beat = 1'b1;
        next_beat_next = now + {16'd0, heartbeat_ms};
      end
      case (phase)
        PH_SILENT: begin
          if (announce_enable && reached(now, next_announce)) begin
            next_announce_next = now + {16'd0, announce_ms};
            f = frame1(ID_ANNOUNCE, B_ANNOUNCE);
          end
        end
        PH_SAWREQ: begin
          if (reached(now, deadline)) begin
            hello_count_next = 2'd0;
            phase_next = PH_HELLO;
          end
        end
        PH_HELLO: begin
          if (hello_count == 2'd0 || reached(now, deadline)) begin
            f = frame1(ID_ANNOUNCE, 8'hB0);
            f.tx_byte1 = 8'h14;
            f.tx_byte2 = 8'h11;
            f.tx_byte4 = 8'h1F;
            hc = hello_count + 2'd1;
            hello_count_next = hc;
            if (hc >= HELLO_REPEATS || hc == 2'd0) begin
              phase_next = PH_WAITPANEL;
              deadline_next = now + {16'd0, ack_timeout_ms};
            end else begin
              deadline_next = now + {16'd0, hello_delay_ms};
            end
          end
        end
        PH_WAITPANEL: begin
          if (panel_seen) begin
            f = frame1(ID_TEXT, B_ON);
            phase_next = PH_REGTEXT;
            deadline_next = now + {16'd0, ack_timeout_ms};
          end else if (reached(now, deadline)) begin
            phase_next = PH_SILENT;
            hello_count_next = 2'd0;
            panel_seen_next = 1'b0;
            registered_next = 1'b0;
            announced_next = 1'b0;
            next_announce_next = now + {16'd0, announce_ms};
          end
        end
        PH_REGTEXT, PH_REGNAV: begin
          if (reached(now, deadline)) begin
            phase_next = PH_SILENT;
            hello_count_next = 2'd0;
            panel_seen_next = 1'b0;
            registered_next = 1'b0;
            announced_next = 1'b0;
            next_announce_next = now + {16'd0, announce_ms};
          end
        end
        PH_SETTLE: begin
          if (reached(now, deadline)) begin
            f = frame1(ID_TEXT, 8'h03);
            f.tx_byte1 = 8'h52;
            f.tx_byte2 = 8'h09;
            phase_next = PH_POWERON;
            deadline_next = now + {16'd0, ack_timeout_ms};
          end
        end
        PH_POWERON: begin
          if (reached(now, deadline)) begin
            phase_next = PH_SETTLE;
            deadline_next = now + {16'd0, retry_ms};
          end
        end
        PH_WARMUP: begin
          if (reached(now, deadline)) begin
            f = frame1(ID_TEXT, 8'h05);
            f.tx_byte1 = 8'h56;
            f.tx_byte2 = clock_text[31:24];
            f.tx_byte3 = clock_text[23:16];
            f.tx_byte4 = clock_text[15:8];
            f.tx_byte5 = clock_text[7:0];
            phase_next = PH_SETCLOCK;
            deadline_next = now + {16'd0, ack_timeout_ms};
          end
        end
        PH_SETCLOCK: begin
          if (reached(now, deadline)) begin
            phase_next = PH_WARMUP;
            deadline_next = now + {16'd0, retry_ms};
          end
        end
        default: begin
        end
      endcase
    end else if (q_req.restart) begin
      phase_next = PH_SILENT;
      hello_count_next = 2'd0;
      panel_seen_next = 1'b0;
      registered_next = 1'b0;
      announced_next = 1'b0;
      next_announce_next = time_ms + {16'd0, announce_ms};
    end else if (q_req.ack_1c1) begin
      f = frame1(ID_PANELACK, B_ACK);
      if (q_req.panel) panel_seen_next = 1'b1;
    end else if (q_req.request) begin
      if (phase == PH_SILENT || phase == PH_SAWREQ) begin
        if (!announced) begin
          announced_next = 1'b1;
          f = frame1(ID_ANNOUNCE, B_ANNOUNCE);
        end else begin
          hello_count_next = 2'd0;
          phase_next = PH_SAWREQ;
          deadline_next = time_ms + {16'd0, hello_delay_ms};
        end
      end else if (registered) begin
        phase_next = PH_SILENT;
        hello_count_next = 2'd0;
        panel_seen_next = 1'b0;
        registered_next = 1'b0;
        announced_next = 1'b0;
        next_announce_next = time_ms + {16'd0, announce_ms};
      end
    end else if (q_req.ack) begin
      case (phase)
        PH_REGTEXT: begin
          if (q_req.ack_id == ID_TEXT[9:0]) begin
            f = frame1(ID_NAV, B_ON);
            phase_next = PH_REGNAV;
            deadline_next = time_ms + {16'd0, ack_timeout_ms};
          end
        end
        PH_REGNAV: begin
          if (q_req.ack_id == ID_NAV[9:0]) begin
            registered_next = 1'b1;
            next_beat_next = time_ms + {16'd0, heartbeat_ms};
            phase_next = PH_SETTLE;
            deadline_next = time_ms + {16'd0, settle_ms};
          end
        end
        PH_POWERON: begin
          if (q_req.ack_id == ID_TEXT[9:0]) begin
            phase_next = PH_WARMUP;
            deadline_next = time_ms + WARMUP_MS;
          end
        end
        PH_SETCLOCK: begin
          if (q_req.ack_id == ID_TEXT[9:0]) begin
            phase_next = PH_DONE;
            deadline_next = 32'd0;
          end
        end
        default: begin
        end
      endcase
    end
    // Order the results: heartbeat first, then the phase frame.
    n_res = beat && f.has_frame;
    r1 = f;
    r0 = beat ? frame1(ID_ANNOUNCE, B_BEAT) : f;
    r0.phase_code = phase_next;
    r1.phase_code = phase_next;
    r0.last_of_item = !n_res;
    r1.last_of_item = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      out_data <= r0;
      pend <= r1;
    end else if (pend_valid && out_ready) begin
      out_data <= pend;
    end
    if (rst) begin
      announce_enable <= 1'b1;
      clock_text <= 32'h3130_3030;
      hello_delay_ms <= 16'd31;
      heartbeat_ms <= 16'd500;
      announce_ms <= 16'd3000;
      ack_timeout_ms <= 16'd2000;
      settle_ms <= 16'd400;
      retry_ms <= 16'd1500;
      time_ms <= '0;
      phase <= PH_SILENT;
      deadline <= '0;
      hello_count <= '0;
      panel_seen <= 1'b0;
      registered <= 1'b0;
      announced <= 1'b0;
      next_beat <= '0;
      next_announce <= 32'd3000;
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ANN_EN: announce_enable <= cfg_wdata[0];
          CFG_CLOCK:  clock_text <= cfg_wdata;
          CFG_HELLO:  hello_delay_ms <= cfg_wdata[15:0];
          CFG_BEAT:   heartbeat_ms <= cfg_wdata[15:0];
          CFG_ANN:    announce_ms <= cfg_wdata[15:0];
          CFG_ACK:    ack_timeout_ms <= cfg_wdata[15:0];
          CFG_SETTLE: settle_ms <= cfg_wdata[15:0];
          CFG_RETRY:  retry_ms <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
      if (q_take) begin
        time_ms <= time_next;
        phase <= phase_next;
        deadline <= deadline_next;
        hello_count <= hello_count_next;
        panel_seen <= panel_seen_next;
        registered <= registered_next;
        announced <= announced_next;
        next_beat <= next_beat_next;
        next_announce <= next_announce_next;
        out_valid <= 1'b1;
        pend_valid <= n_res;
      end else if (pend_valid && out_ready) begin
        pend_valid <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/display_can_handshake_sequencer.sv @@
// Display CAN handshake sequencer, radio side. A request reaching an empty
// block is queued in the front part, taken by the back part, and its first
// result is registered in the output register. Throughput, set by the single
// output register and its pending slot: one request per cycle when it gives
// one result and the output is not stalled; two results hold off the next.
// Reset (rst, synchronous) restores configuration defaults and session state.
// Depends on dchs_pkg, dchs_front and dchs_back.
module display_can_handshake_sequencer import dchs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // The front classifies each request and queues it; the back owns all
  // session state and retires one queued request whenever its output side
  // has room, so input and output stall independently.
  logic q_valid, q_take;
  req_t q_req;

  dchs_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
  );

  dchs_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_take(q_take), .q_req(q_req),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // A result that is not the last of its request is always followed by one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_of_item |=> out_valid)
    else $error("second result missing");

  // A result without a frame carries no identifier.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.has_frame |-> out_data.tx_id == 11'd0)
    else $error("empty result with identifier");

  // The phase never leaves its coded range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.phase_code <= PH_DONE)
    else $error("phase code out of range");

endmodule
